// ----- design/trmw_pkg.sv -----
// ----------------------------------------------------------------------------
// trmw_pkg: shared types and constants of the tangent radial mesh warp core
// Transaction types, cell payload structs, CORDIC table and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package trmw_pkg;

  localparam int MAX_GRID = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [10:0] GRID_COLS_RESET    = 11'd80;
  localparam logic [10:0] GRID_ROWS_RESET    = 11'd60;
  localparam logic [19:0] FOCAL_LENGTH_RESET = 20'd18432;
  localparam logic [15:0] OUT_SCALE_RESET    = 16'd4096;
  localparam logic [23:0] TEX_DIM            = 24'd212365;

  localparam int SQ_STAGES     = 27;
  localparam int THETA_STAGES  = 31;
  localparam int CORDIC_STAGES = 30;
  localparam int TAN_STAGES    = 40;
  localparam int U_STAGES      = 25;

  localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
  localparam logic [30:0]        THETA_LIMIT = 31'd1685581137;
  localparam logic [24:0]        TEX_MAX     = 25'h1FF_FFFF;
  localparam logic [31:0]        POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]        NEG_MAX     = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS    = 3'd0,
    REG_GRID_ROWS    = 3'd1,
    REG_FOCAL_LENGTH = 3'd2,
    REG_OUT_SCALE    = 3'd3,
    REG_TEX_STEP_X   = 3'd4,
    REG_TEX_STEP_Y   = 3'd5
  } trmw_reg_e;

  typedef struct packed {
    logic [9:0] col_index;
    logic [9:0] row_index;
  } trmw_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [24:0]        tex_u;
    logic [24:0]        tex_v;
    logic               warp_saturated;
  } trmw_result_t;

  typedef struct packed {
    logic signed [12:0] hx;
    logic signed [12:0] hy;
    logic [24:0]        tex_u;
    logic [24:0]        tex_v;
    logic               zero;
    logic               big;
    logic [26:0]        rq;
    logic [39:0]        tq;
  } trmw_side_t;

  typedef struct packed {
    logic       valid;
    trmw_side_t side;
    logic [28:0] rem;
    logic [26:0] root;
    logic [53:0] rad;
  } trmw_sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [39:0] num;
    logic [39:0] quo;
    logic [31:0] dvs;
  } trmw_div_lane_t;

  typedef struct packed {
    logic                  valid;
    trmw_side_t            side;
    trmw_div_lane_t [1:0]  lane;
  } trmw_div_t;

  typedef struct packed {
    logic               valid;
    trmw_side_t         side;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } trmw_cordic_t;

  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837829;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      23: a = 30'd128;
      24: a = 30'd64;
      25: a = 30'd32;
      26: a = 30'd16;
      27: a = 30'd8;
      28: a = 30'd4;
      29: a = 30'd2;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- design/trmw_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// trmw_sqrt_cell: one digit of the radius square root
// Resolves one root bit per cell from two radicand bits.
// ----------------------------------------------------------------------------
`default_nettype none

module trmw_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  trmw_pkg::trmw_sqrt_t d,
  output trmw_pkg::trmw_sqrt_t q
);
  import trmw_pkg::*;

  logic [30:0] rem_sh;
  logic [30:0] trial;
  logic        ge;
  logic [30:0] diff;

  always_comb begin
    rem_sh = {d.rem, d.rad[53:52]};
    trial  = {2'b00, d.root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.side <= d.side;
      q.rem  <= ge ? diff[28:0] : rem_sh[28:0];
      q.root <= {d.root[25:0], ge};
      q.rad  <= {d.rad[51:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

// ----- design/trmw_div_cell.sv -----
// ----------------------------------------------------------------------------
// trmw_div_cell: one quotient bit of a restoring divider, two lanes
// Shifts in one dividend bit per lane and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module trmw_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  trmw_pkg::trmw_div_t d,
  output trmw_pkg::trmw_div_t q
);
  import trmw_pkg::*;

  trmw_div_lane_t [1:0] nxt;

  always_comb begin
    logic [32:0] t;
    logic [32:0] dv;
    logic        ge;
    for (int k = 0; k < 2; k++) begin
      t  = {d.lane[k].rem, d.lane[k].num[39]};
      dv = {1'b0, d.lane[k].dvs};
      ge = t >= dv;
      nxt[k].rem = ge ? 32'(t - dv) : t[31:0];
      nxt[k].num = {d.lane[k].num[38:0], 1'b0};
      nxt[k].quo = {d.lane[k].quo[38:0], ge};
      nxt[k].dvs = d.lane[k].dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.side <= d.side;
      q.lane <= nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/trmw_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// trmw_cordic_cell: one micro-rotation of the sine/cosine CORDIC
// Rotates by the table angle of its step toward the residual angle.
// ----------------------------------------------------------------------------
`default_nettype none

module trmw_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  trmw_pkg::trmw_cordic_t d,
  output trmw_pkg::trmw_cordic_t q
);
  import trmw_pkg::*;

  localparam logic signed [33:0] ATAN = {4'b0000, atan_q30(STEP)};

  logic signed [33:0] dx;
  logic signed [33:0] dy;

  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.side <= d.side;
      if (!d.z[33]) begin
        q.x <= d.x - dx;
        q.y <= d.y + dy;
        q.z <= d.z - ATAN;
      end else begin
        q.x <= d.x + dx;
        q.y <= d.y - dy;
        q.z <= d.z + ATAN;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/tangent_radial_mesh_warp_core.sv -----
// ----------------------------------------------------------------------------
// tangent_radial_mesh_warp_core: tangent-model radial lens warp of grid points
// Takes a grid column/row, returns the warped Q16.16 vertex and Q1.24 texture
// coordinates through a chain of square-root, divider and CORDIC cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall/item carries one grid point per
//   transaction; output channel result_valid/result_stall/result returns one
//   result per point, in order.
//   From acceptance to result_valid a transaction passes 2 front stages,
//   27 root cells, 31 angle divider cells, 30 CORDIC cells, 40 tangent
//   divider cells, 25 axis divider cells, 5 multiply stages, output register.
//   Throughput is one transaction per cycle while the skid is empty; all cells
//   advance together. A skid register behind the output register absorbs one
//   result when the receiver stalls; while it is full the whole chain holds
//   and item_stall is high.
//   Reset clears all valid bits and loads the register defaults.
//   Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
//   once and must only be made while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tangent_radial_mesh_warp_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  trmw_pkg::trmw_item_t                item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output trmw_pkg::trmw_result_t              result,
  input  logic                                cfg_write_en,
  input  logic [trmw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trmw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import trmw_pkg::*;

  logic [10:0] grid_cols;
  logic [10:0] grid_rows;
  logic [19:0] focal_length;
  logic [15:0] out_scale;
  logic [23:0] tex_step_x;
  logic [23:0] tex_step_y;
  logic [35:0] sfl;

  logic         adv;
  logic         skid_valid;
  trmw_result_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= GRID_COLS_RESET;
      grid_rows    <= GRID_ROWS_RESET;
      focal_length <= FOCAL_LENGTH_RESET;
      out_scale    <= OUT_SCALE_RESET;
      tex_step_x   <= TEX_DIM;
      tex_step_y   <= TEX_DIM;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_GRID_COLS:    grid_cols    <= cfg_data[10:0];
        REG_GRID_ROWS:    grid_rows    <= cfg_data[10:0];
        REG_FOCAL_LENGTH: focal_length <= cfg_data[19:0];
        REG_OUT_SCALE:    out_scale    <= cfg_data[15:0];
        REG_TEX_STEP_X:   tex_step_x   <= cfg_data;
        REG_TEX_STEP_Y:   tex_step_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sfl <= 36'(out_scale) * 36'(focal_length);
  end

  assign adv        = !skid_valid;
  assign item_stall = skid_valid;

  // front stage 0: centering and texture coordinates
  logic       s0_valid;
  trmw_side_t s0_side;
  trmw_side_t s0_next;

  always_comb begin
    logic [10:0] cols_eff;
    logic [10:0] rows_eff;
    logic [33:0] tu;
    logic [33:0] tv;
    cols_eff = ({2'b00, grid_cols} > 13'(MAX_GRID)) ? 11'(MAX_GRID) : grid_cols;
    rows_eff = ({2'b00, grid_rows} > 13'(MAX_GRID)) ? 11'(MAX_GRID) : grid_rows;
    tu = 34'(item.col_index) * 34'(tex_step_x);
    tv = 34'(item.row_index) * 34'(tex_step_y);
    s0_next       = '0;
    s0_next.hx    = $signed({2'b00, item.col_index, 1'b0}) - $signed({2'b00, cols_eff})
                    + 13'sd1;
    s0_next.hy    = $signed({2'b00, item.row_index, 1'b0}) - $signed({2'b00, rows_eff})
                    + 13'sd1;
    s0_next.tex_u = (tu > 34'(TEX_MAX)) ? TEX_MAX : tu[24:0];
    s0_next.tex_v = (tv > 34'(TEX_MAX)) ? TEX_MAX : tv[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= item_valid;
    end
    if (adv) begin
      s0_side <= s0_next;
    end
  end

  // front stage 1: squared radius
  logic        s1_valid;
  trmw_side_t  s1_side;
  trmw_side_t  s1_next;
  logic [23:0] s1_r2;
  logic signed [26:0] r2_sum;

  always_comb begin
    logic signed [26:0] hxw;
    logic signed [26:0] hyw;
    hxw          = 27'(s0_side.hx);
    hyw          = 27'(s0_side.hy);
    r2_sum       = hxw * hxw + hyw * hyw;
    s1_next      = s0_side;
    s1_next.zero = (r2_sum == 27'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
    if (adv) begin
      s1_side <= s1_next;
      s1_r2   <= r2_sum[23:0];
    end
  end

  // square root chain
  trmw_sqrt_t sq_c [SQ_STAGES+1];

  always_comb begin
    sq_c[0].valid = s1_valid;
    sq_c[0].side  = s1_side;
    sq_c[0].rem   = '0;
    sq_c[0].root  = '0;
    sq_c[0].rad   = {s1_r2, 30'd0};
  end

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    trmw_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (sq_c[i]),
      .q   (sq_c[i+1])
    );
  end

  // angle divider chain: theta = rq * 2^22 / focal_length
  trmw_div_t th_c [THETA_STAGES+1];

  always_comb begin
    logic [26:0] rq;
    rq = sq_c[SQ_STAGES].root;
    th_c[0].valid    = sq_c[SQ_STAGES].valid;
    th_c[0].side     = sq_c[SQ_STAGES].side;
    th_c[0].side.rq  = rq;
    th_c[0].side.big = (focal_length == 20'd0) ||
                       ({2'b00, rq} >= {focal_length, 9'd0});
    th_c[0].lane     = '0;
    th_c[0].lane[0].rem = {14'd0, rq[26:9]};
    th_c[0].lane[0].num = {rq[8:0], 31'd0};
    th_c[0].lane[0].dvs = {12'd0, focal_length};
  end

  for (genvar i = 0; i < THETA_STAGES; i++) begin : g_th
    trmw_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (th_c[i]),
      .q   (th_c[i+1])
    );
  end

  // CORDIC chain
  trmw_cordic_t cd_c [CORDIC_STAGES+1];

  always_comb begin
    logic [30:0] theta;
    theta = th_c[THETA_STAGES].lane[0].quo[30:0];
    cd_c[0].valid    = th_c[THETA_STAGES].valid;
    cd_c[0].side     = th_c[THETA_STAGES].side;
    cd_c[0].side.big = th_c[THETA_STAGES].side.big || (theta >= THETA_LIMIT);
    cd_c[0].x        = CORDIC_X0;
    cd_c[0].y        = '0;
    cd_c[0].z        = {3'b000, theta};
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cd
    trmw_cordic_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (cd_c[i]),
      .q   (cd_c[i+1])
    );
  end

  // tangent divider chain: tq = sin * 2^24 / cos
  trmw_div_t tn_c [TAN_STAGES+1];

  always_comb begin
    logic [30:0] sn;
    sn = cd_c[CORDIC_STAGES].y[33] ? 31'd0 : cd_c[CORDIC_STAGES].y[30:0];
    tn_c[0].valid    = cd_c[CORDIC_STAGES].valid;
    tn_c[0].side     = cd_c[CORDIC_STAGES].side;
    tn_c[0].side.big = cd_c[CORDIC_STAGES].side.big || cd_c[CORDIC_STAGES].x[33] ||
                       (cd_c[CORDIC_STAGES].x == 34'sd0);
    tn_c[0].lane     = '0;
    tn_c[0].lane[0].rem = {17'd0, sn[30:16]};
    tn_c[0].lane[0].num = {sn[15:0], 24'd0};
    tn_c[0].lane[0].dvs = cd_c[CORDIC_STAGES].x[31:0];
  end

  for (genvar i = 0; i < TAN_STAGES; i++) begin : g_tn
    trmw_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (tn_c[i]),
      .q   (tn_c[i+1])
    );
  end

  // per-axis divider chain: U = |h| * 2^39 / rq
  trmw_div_t ud_c [U_STAGES+1];

  always_comb begin
    logic [12:0] ax;
    logic [12:0] ay;
    ax = tn_c[TAN_STAGES].side.hx[12] ? 13'(-tn_c[TAN_STAGES].side.hx)
                                      : 13'(tn_c[TAN_STAGES].side.hx);
    ay = tn_c[TAN_STAGES].side.hy[12] ? 13'(-tn_c[TAN_STAGES].side.hy)
                                      : 13'(tn_c[TAN_STAGES].side.hy);
    ud_c[0].valid   = tn_c[TAN_STAGES].valid;
    ud_c[0].side    = tn_c[TAN_STAGES].side;
    ud_c[0].side.tq = tn_c[TAN_STAGES].lane[0].quo;
    ud_c[0].lane    = '0;
    ud_c[0].lane[0].rem = {7'd0, ax[10:0], 14'd0};
    ud_c[0].lane[1].rem = {7'd0, ay[10:0], 14'd0};
    ud_c[0].lane[0].dvs = {5'd0, tn_c[TAN_STAGES].side.rq};
    ud_c[0].lane[1].dvs = {5'd0, tn_c[TAN_STAGES].side.rq};
  end

  for (genvar i = 0; i < U_STAGES; i++) begin : g_ud
    trmw_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (ud_c[i]),
      .q   (ud_c[i+1])
    );
  end

  // multiply stages
  logic        m1_valid, m2_valid, m3_valid, m4_valid, m5_valid;
  trmw_side_t  m1_side, m2_side, m3_side, m4_side, m5_side;
  logic [48:0] m1_phx, m1_phy;
  logic [47:0] m1_plx, m1_ply;
  logic [36:0] m2_px, m2_py;
  logic [3:0][46:0] m3_ppx, m3_ppy;
  logic [56:0] m4_sx01, m4_sx23, m4_sy01, m4_sy23;
  logic [48:0] m5_mx, m5_my;

  logic [24:0] ux;
  logic [24:0] uy;
  logic [60:0] fx;
  logic [60:0] fy;
  logic [76:0] prod_x;
  logic [76:0] prod_y;

  always_comb begin
    ux     = ud_c[U_STAGES].lane[0].quo[24:0];
    uy     = ud_c[U_STAGES].lane[1].quo[24:0];
    fx     = {m1_phx, 12'd0} + 61'(m1_plx);
    fy     = {m1_phy, 12'd0} + 61'(m1_ply);
    prod_x = 77'(m4_sx01) + {m4_sx23, 20'd0};
    prod_y = 77'(m4_sy01) + {m4_sy23, 20'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      m5_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= ud_c[U_STAGES].valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      m5_valid <= m4_valid;
    end
    if (adv) begin
      m1_side <= ud_c[U_STAGES].side;
      m1_phx  <= 49'(sfl) * 49'(ux[24:12]);
      m1_plx  <= 48'(sfl) * 48'(ux[11:0]);
      m1_phy  <= 49'(sfl) * 49'(uy[24:12]);
      m1_ply  <= 48'(sfl) * 48'(uy[11:0]);
      m2_side <= m1_side;
      m2_px   <= fx[60:24];
      m2_py   <= fy[60:24];
      m3_side <= m2_side;
      for (int k = 0; k < 4; k++) begin
        m3_ppx[k] <= 47'(m2_px) * 47'(m2_side.tq[10*k +: 10]);
        m3_ppy[k] <= 47'(m2_py) * 47'(m2_side.tq[10*k +: 10]);
      end
      m4_side <= m3_side;
      m4_sx01 <= 57'(m3_ppx[0]) + {m3_ppx[1], 10'd0};
      m4_sx23 <= 57'(m3_ppx[2]) + {m3_ppx[3], 10'd0};
      m4_sy01 <= 57'(m3_ppy[0]) + {m3_ppy[1], 10'd0};
      m4_sy23 <= 57'(m3_ppy[2]) + {m3_ppy[3], 10'd0};
      m5_side <= m4_side;
      m5_mx   <= prod_x[76:28];
      m5_my   <= prod_y[76:28];
    end
  end

  // final assembly
  function automatic logic [32:0] axis_out(input logic neg, input logic [48:0] m);
    logic [48:0] lim;
    logic        sat;
    logic [31:0] mm;
    lim = neg ? 49'(NEG_MAX) : 49'(POS_MAX);
    sat = m > lim;
    mm  = sat ? lim[31:0] : m[31:0];
    return {sat, neg ? (~mm + 32'd1) : mm};
  endfunction

  function automatic logic [31:0] sign_clamp(input logic signed [12:0] h);
    logic [31:0] v;
    if (h > 13'sd0) begin
      v = POS_MAX;
    end else if (h < 13'sd0) begin
      v = NEG_MAX;
    end else begin
      v = 32'd0;
    end
    return v;
  endfunction

  trmw_result_t fin;

  always_comb begin
    logic [32:0] ox;
    logic [32:0] oy;
    ox = axis_out(m5_side.hx[12], m5_mx);
    oy = axis_out(m5_side.hy[12], m5_my);
    fin.tex_u = m5_side.tex_u;
    fin.tex_v = m5_side.tex_v;
    if (m5_side.zero) begin
      fin.vertex_x       = '0;
      fin.vertex_y       = '0;
      fin.warp_saturated = 1'b0;
    end else if (m5_side.big) begin
      fin.vertex_x       = sign_clamp(m5_side.hx);
      fin.vertex_y       = sign_clamp(m5_side.hy);
      fin.warp_saturated = 1'b1;
    end else begin
      fin.vertex_x       = ox[31:0];
      fin.vertex_y       = oy[31:0];
      fin.warp_saturated = ox[32] | oy[32];
    end
  end

  // output register and skid
  logic out_take;
  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (m5_valid) begin
      if (result_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        result <= skid_data;
      end
    end else if (m5_valid) begin
      if (result_valid && !out_take) begin
        skid_data <= fin;
      end else begin
        result <= fin;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/trmw_checker.sv -----
// ----------------------------------------------------------------------------
// trmw_port_checker: port-level checks of the mesh warp core
// Output handshake stability, skid/stall relation and reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module trmw_port_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input trmw_pkg::trmw_result_t          result
);
  import trmw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // input only backs up once a result is parked at the output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item_stall without a pending result");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("handshake not idle after reset");

endmodule

bind tangent_radial_mesh_warp_core trmw_port_checker u_trmw_port_checker (.*);

`default_nettype wire
